>>> hdl/assert_macros.svh
// Assertion macros for the RTL of the circular convolution engine.
// Standalone header; ccv_dp takes it by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CCV_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CCV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CCV_ASSERT(lbl, clk, rst_n, prop, msg)
`define CCV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hdl/ccv_pkg.sv
// Types and constants of the circular convolution engine.
// No dependencies; used by the register, controller, datapath and top files.
package ccv_pkg;

	localparam int SIZE_W = 6;
	localparam int IDX_W = 5;
	localparam int VAL_W = 16;
	localparam int PROD_W = 32;
	localparam int ACC_W = 44;
	localparam int RES_W = 42;

	localparam logic [1:0] ACT_KERNEL = 2'd0;
	localparam logic [1:0] ACT_SAMPLE = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	localparam logic signed [ACC_W-1:0] RES_MAX = ACC_W'(64'sd2199023255551);
	localparam logic signed [ACC_W-1:0] RES_MIN = -RES_MAX - ACC_W'(1);

	localparam logic [2:0] REG_WIDTH = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd4;

	typedef struct packed {
		logic wr_kernel;
		logic wr_sample;
		logic start;
		logic mod_step;
		logic loop_init;
		logic loop_step;
		logic publish;
	} ccv_cmd_t;

	typedef struct packed {
		logic mod_done;
		logic last;
		logic pipe_idle;
		logic out_free;
	} ccv_status_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] raw,
			input int limit);
		logic [SIZE_W-1:0] res;
		if (raw == '0) begin
			res = SIZE_W'(1);
		end else if (32'(raw) > limit) begin
			res = SIZE_W'(limit);
		end else begin
			res = raw;
		end
		return res;
	endfunction

endpackage

>>> hdl/ccv_regs.sv
// APB configuration registers: columns and rows in use.
// Depends on ccv_pkg.
module ccv_regs import ccv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output logic [SIZE_W-1:0] width_in_use,
	output logic [SIZE_W-1:0] height_in_use
);

	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic              wr_en;
	logic [2:0]        reg_sel;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign reg_sel = {paddr[2], 2'b00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= SIZE_W'(32);
			height_q <= SIZE_W'(32);
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_WIDTH: width_q <= pwdata[SIZE_W-1:0];
				REG_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_WIDTH: prdata = {{(32-SIZE_W){1'b0}}, width_q};
			REG_HEIGHT: prdata = {{(32-SIZE_W){1'b0}}, height_q};
			default: prdata = '0;
		endcase
	end

	assign width_in_use = width_q;
	assign height_in_use = height_q;

endmodule

>>> hdl/ccv_ctrl.sv
// Controller state machine of the convolution engine: sequences loads,
// index reduction, the multiply-accumulate sweep and result delivery. Uses ccv_pkg.
module ccv_ctrl import ccv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  logic [1:0]  action,
	output logic        cmd_stall,
	output ccv_cmd_t    cmd,
	input  ccv_status_t status
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_REDUCE = 4'b0010,
		S_RUN    = 4'b0100,
		S_DRAIN  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign cmd_stall = (state_q != S_IDLE);
	assign accept = cmd_valid & ~cmd_stall;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.wr_kernel = (action == ACT_KERNEL);
					cmd.wr_sample = (action == ACT_SAMPLE);
					if (action == ACT_READ) begin
						cmd.start = 1'b1;
						state_d = S_REDUCE;
					end
				end
			end
			S_REDUCE: begin
				if (status.mod_done) begin
					cmd.loop_init = 1'b1;
					state_d = S_RUN;
				end else begin
					cmd.mod_step = 1'b1;
				end
			end
			S_RUN: begin
				cmd.loop_step = 1'b1;
				if (status.last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (status.pipe_idle && status.out_free) begin
					cmd.publish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hdl/ccv_dp.sv
// Datapath of the convolution engine: the two coefficient stores, index counters,
// one multiply-accumulate pipeline and the result register. Uses ccv_pkg and the macros.
`include "assert_macros.svh"
module ccv_dp import ccv_pkg::*; #(
	parameter int GRID_WIDTH = 32,
	parameter int GRID_HEIGHT = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ccv_cmd_t                cmd,
	output ccv_status_t             status,
	input  logic [IDX_W-1:0]        col,
	input  logic [IDX_W-1:0]        row,
	input  logic signed [VAL_W-1:0] value,
	input  logic [SIZE_W-1:0]       width_in_use,
	input  logic [SIZE_W-1:0]       height_in_use,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic [IDX_W-1:0]        out_col,
	output logic [IDX_W-1:0]        out_row,
	output logic signed [RES_W-1:0] result
);

	localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic signed [VAL_W-1:0]  kmem [DEPTH];
	logic signed [VAL_W-1:0]  smem [DEPTH];

	logic [SIZE_W-1:0]        x_q, y_q, w_q, h_q;
	logic [IDX_W-1:0]         col_q, row_q;
	logic [SIZE_W-1:0]        i_q, j_q, ki_q, kj_q, kj0_q;
	logic [SIZE_W-1:0]        ki_init, kj_init;
	logic [AW-1:0]            wr_addr, s_addr, k_addr;
	logic                     in_grid;

	logic                     v_s1, v_s2;
	logic signed [VAL_W-1:0]  samp_s1, kern_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;

	logic                     rv_q;
	logic [IDX_W-1:0]         ocol_q, orow_q;
	logic signed [RES_W-1:0]  res_q;
	logic signed [ACC_W-1:0]  sat;

	assign in_grid = (32'(col) < GRID_WIDTH) && (32'(row) < GRID_HEIGHT);
	assign wr_addr = AW'(32'(col) * GRID_HEIGHT + 32'(row));
	assign s_addr = AW'(32'(i_q) * GRID_HEIGHT + 32'(j_q));
	assign k_addr = AW'(32'(ki_q) * GRID_HEIGHT + 32'(kj_q));

	always_ff @(posedge clk) begin
		if (cmd.wr_kernel && in_grid) begin
			kmem[wr_addr] <= value;
		end
		if (cmd.wr_sample && in_grid) begin
			smem[wr_addr] <= value;
		end
		if (cmd.loop_step) begin
			kern_s1 <= kmem[k_addr];
			samp_s1 <= smem[s_addr];
		end
	end

	assign ki_init = (x_q + SIZE_W'(1) == w_q) ? '0 : x_q + SIZE_W'(1);
	assign kj_init = (y_q + SIZE_W'(1) == h_q) ? '0 : y_q + SIZE_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q <= {1'b0, col};
			y_q <= {1'b0, row};
			w_q <= clamp_size(width_in_use, GRID_WIDTH);
			h_q <= clamp_size(height_in_use, GRID_HEIGHT);
			col_q <= col;
			row_q <= row;
		end else if (cmd.mod_step) begin
			if (x_q >= w_q) begin
				x_q <= x_q - w_q;
			end
			if (y_q >= h_q) begin
				y_q <= y_q - h_q;
			end
		end
		if (cmd.loop_init) begin
			i_q <= '0;
			j_q <= '0;
			ki_q <= ki_init;
			kj_q <= kj_init;
			kj0_q <= kj_init;
		end else if (cmd.loop_step) begin
			if (j_q == h_q - SIZE_W'(1)) begin
				j_q <= '0;
				kj_q <= kj0_q;
				i_q <= i_q + SIZE_W'(1);
				ki_q <= (ki_q == '0) ? w_q - SIZE_W'(1) : ki_q - SIZE_W'(1);
			end else begin
				j_q <= j_q + SIZE_W'(1);
				kj_q <= (kj_q == '0) ? h_q - SIZE_W'(1) : kj_q - SIZE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= samp_s1 * kern_s1;
		if (cmd.loop_init) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.loop_step;
			v_s2 <= v_s1;
		end
	end

	always_comb begin
		priority if (acc_q > RES_MAX) begin
			sat = RES_MAX;
		end else if (acc_q < RES_MIN) begin
			sat = RES_MIN;
		end else begin
			sat = acc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			ocol_q <= col_q;
			orow_q <= row_q;
			res_q <= sat[RES_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
		end else if (cmd.publish) begin
			rv_q <= 1'b1;
		end else if (!result_stall) begin
			rv_q <= 1'b0;
		end
	end

	assign status.mod_done = (x_q < w_q) && (y_q < h_q);
	assign status.last = (i_q == w_q - SIZE_W'(1)) && (j_q == h_q - SIZE_W'(1));
	assign status.pipe_idle = ~v_s1 & ~v_s2;
	assign status.out_free = ~rv_q | ~result_stall;

	assign result_valid = rv_q;
	assign out_col = ocol_q;
	assign out_row = orow_q;
	assign result = res_q;

	`CCV_ASSERT(a_publish_after_drain, clk, arst_n, cmd.publish |-> (!v_s1 && !v_s2), "result published with products still in flight")
	`CCV_ASSERT(a_sweep_after_reduce, clk, arst_n, cmd.loop_step |-> (x_q < w_q && y_q < h_q), "sweep started before the indices were reduced")
	`CCV_ASSERT(a_index_range, clk, arst_n, cmd.loop_step |-> (i_q < w_q && j_q < h_q && ki_q < w_q && kj_q < h_q), "store index outside the size in use")
	`CCV_ASSERT_NEXT(a_no_overwrite, clk, arst_n, rv_q && result_stall && !cmd.publish, rv_q && $stable(res_q), "waiting result lost or changed")

endmodule

>>> hdl/circular_conv2d_engine_top.sv
// Channel   Valid         Stall         Payload
// command   cmd_valid     cmd_stall     action, col, row, value
// result    result_valid  result_stall  out_col, out_row, result
// A load item is written in its accepting cycle. A read item first reduces col mod W and row mod H
// by repeated subtraction (at most 31 subtractions), then loads the counters, sweeps with one
// multiply-accumulate per cell and drains the pipe.
// The command channel stalls for the whole read; loads are taken while a result waits.
// A finished read waits in the drain state until the pipe is empty and the result register holds no stalled item.
// Reset clears control state; the stores hold nothing until written.
// Top level: instantiates ccv_regs, ccv_ctrl and ccv_dp; uses ccv_pkg.
module circular_conv2d_engine_top import ccv_pkg::*; #(
	parameter int GRID_WIDTH = 32,
	parameter int GRID_HEIGHT = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  logic                    cmd_valid,
	output logic                    cmd_stall,
	input  logic [1:0]              action,
	input  logic [IDX_W-1:0]        col,
	input  logic [IDX_W-1:0]        row,
	input  logic signed [VAL_W-1:0] value,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic [IDX_W-1:0]        out_col,
	output logic [IDX_W-1:0]        out_row,
	output logic signed [RES_W-1:0] result
);

	logic [SIZE_W-1:0] width_in_use;
	logic [SIZE_W-1:0] height_in_use;
	ccv_cmd_t          cmd;
	ccv_status_t       status;

	ccv_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.width_in_use  (width_in_use),
		.height_in_use (height_in_use)
	);

	ccv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.action    (action),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.status    (status)
	);

	ccv_dp #(
		.GRID_WIDTH  (GRID_WIDTH),
		.GRID_HEIGHT (GRID_HEIGHT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.col           (col),
		.row           (row),
		.value         (value),
		.width_in_use  (width_in_use),
		.height_in_use (height_in_use),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.out_col       (out_col),
		.out_row       (out_row),
		.result        (result)
	);

endmodule
